FILE: hw/rtl/bfhb_pkg.sv
// Shared constants, mode codes and controller states for the history buffer.
// No dependencies; the unit imports this package, bfhb_ram does not.
package bfhb_pkg;

   localparam int HISTORY_DEPTH = 32;
   localparam int PAGE_BITS     = 16;
   localparam int IDX_W         = (HISTORY_DEPTH > 2) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

   typedef enum logic [3:0] {
      MODE_RECORD   = 4'd0,
      MODE_BACK     = 4'd1,
      MODE_FORWARD  = 4'd2,
      MODE_PEEK_BK  = 4'd3,
      MODE_PEEK_FW  = 4'd4,
      MODE_PURGE    = 4'd5,
      MODE_DROP_BK  = 4'd6,
      MODE_DROP_FW  = 4'd7,
      MODE_LIST     = 4'd8
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_NAV_WAIT,
      ST_WALK,
      ST_APPEND,
      ST_LIST_RD,
      ST_LIST_WAIT,
      ST_EMIT
   } state_type;

endpackage

FILE: hw/rtl/bfhb_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module bfhb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/back_forward_history_buffer_unit.sv
// Back/forward history buffer: controller around one history RAM.
// Depends on bfhb_pkg and bfhb_ram.
// Purge and drop walk the stored entries through the RAM read port, one entry a cycle;
// a record that overflows walks them as well.
// One item at a time; reset (synchronous) empties the history, RAM contents stay.
module back_forward_history_buffer_unit
   import bfhb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_mode,
   input  logic [15:0] req_source_page,
   input  logic [15:0] req_target_page,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_page_out,
   output logic        rsp_found,
   output logic        rsp_can_back,
   output logic        rsp_can_forward,
   output logic [5:0]  rsp_entry_count,
   output logic [4:0]  rsp_cursor_pos,
   output logic        rsp_last
);

   // control state
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [IDX_W-1:0]     cur_ff, cur_in;
   logic                 pend_ff, pend_in;
   // item and walk working registers
   logic [3:0]           mode_ff, mode_in;
   logic [PAGE_BITS-1:0] src_ff, src_in, dst_ff, dst_in;
   logic [CNT_W-1:0]     rd_ff, rd_in, wr_ff, wr_in, end_ff, end_in;
   logic [IDX_W-1:0]     pidx_ff, pidx_in, drop_ff, drop_in;
   logic                 by_value_ff, by_value_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic                 found_ff, found_in, last_ff, last_in;

   // RAM port
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr, mem_raddr;
   logic [PAGE_BITS-1:0] mem_wdata, mem_rdata;

   logic [CNT_W-1:0] cur_ext;
   logic             can_b, can_f, walk_hit, walk_done;
   logic [CNT_W-1:0] cnt_dec;

   assign cur_ext   = CNT_W'(cur_ff);
   assign can_b     = (cur_ff != '0);
   assign can_f     = ((cur_ext + 1'b1) < cnt_ff);
   assign cnt_dec   = cnt_ff - 1'b1;
   assign walk_hit  = by_value_ff ? (mem_rdata == dst_ff) : (pidx_ff == drop_ff);
   assign walk_done = (rd_ff == end_ff) && !pend_ff;

   bfhb_ram #(.WIDTH(PAGE_BITS), .DEPTH(HISTORY_DEPTH), .AW(IDX_W)) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_EXEC;
         ST_EXEC: begin
            unique case (mode_ff)
               MODE_RECORD: begin
                  if (dst_ff == '0) state_in = ST_EMIT;
                  else if (cnt_ff != '0 && (cur_ext + 1'b1) == CNT_W'(HISTORY_DEPTH))
                     state_in = ST_WALK;
                  else state_in = ST_APPEND;
               end
               MODE_BACK, MODE_PEEK_BK: state_in = can_b ? ST_NAV_WAIT : ST_EMIT;
               MODE_FORWARD, MODE_PEEK_FW: state_in = can_f ? ST_NAV_WAIT : ST_EMIT;
               MODE_PURGE: state_in = ST_WALK;
               MODE_DROP_BK: state_in = can_b ? ST_WALK : ST_EMIT;
               MODE_DROP_FW: state_in = can_f ? ST_WALK : ST_EMIT;
               MODE_LIST: state_in = can_b ? ST_LIST_WAIT : ST_EMIT;
               default: state_in = ST_EMIT;
            endcase
         end
         ST_NAV_WAIT: state_in = ST_EMIT;
         ST_WALK: begin
            if (walk_done) state_in = (mode_ff == MODE_RECORD) ? ST_APPEND : ST_EMIT;
         end
         ST_APPEND:    state_in = ST_EMIT;
         ST_LIST_RD:   state_in = ST_LIST_WAIT;
         ST_LIST_WAIT: state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_ready) state_in = last_ff ? ST_IDLE : ST_LIST_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath register updates.
   always_comb begin
      cnt_in      = cnt_ff;
      cur_in      = cur_ff;
      pend_in     = 1'b0;
      mode_in     = mode_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      rd_in       = rd_ff;
      wr_in       = wr_ff;
      end_in      = end_ff;
      pidx_in     = pidx_ff;
      drop_in     = drop_ff;
      by_value_in = by_value_ff;
      page_in     = page_ff;
      found_in    = found_ff;
      last_in     = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            mode_in  = req_mode;
            src_in   = PAGE_BITS'(req_source_page);
            dst_in   = PAGE_BITS'(req_target_page);
            page_in  = '0;
            found_in = 1'b0;
            last_in  = 1'b1;
         end
         ST_EXEC: begin
            // set up a walk over the whole history; modes that skip it ignore this
            rd_in       = '0;
            wr_in       = '0;
            end_in      = cnt_ff;
            by_value_in = 1'b0;
            unique case (mode_ff)
               MODE_RECORD: begin
                  if (dst_ff != '0) begin
                     if (cnt_ff == '0) begin
                        cnt_in = (src_ff != '0) ? CNT_W'(1) : '0;
                     end else begin
                        cnt_in  = cur_ext + 1'b1;
                        end_in  = cur_ext + 1'b1;
                        drop_in = '0;
                     end
                  end
               end
               MODE_BACK:    if (can_b) cur_in = cur_ff - 1'b1;
               MODE_FORWARD: if (can_f) cur_in = cur_ff + 1'b1;
               MODE_PURGE:   by_value_in = 1'b1;
               MODE_DROP_BK: drop_in = cur_ff - 1'b1;
               MODE_DROP_FW: drop_in = cur_ff + 1'b1;
               MODE_LIST:    rd_in = cur_ext - 1'b1;
               default: ;
            endcase
         end
         ST_NAV_WAIT: begin
            page_in  = mem_rdata;
            found_in = 1'b1;
         end
         ST_WALK: begin
            if (rd_ff != end_ff) begin
               pend_in = 1'b1;
               pidx_in = rd_ff[IDX_W-1:0];
               rd_in   = rd_ff + 1'b1;
            end
            if (pend_ff) begin
               if (walk_hit) begin
                  cnt_in = cnt_dec;
                  if (by_value_ff) begin
                     if (wr_ff < cur_ext) begin
                        cur_in = cur_ff - 1'b1;
                     end else if (wr_ff == cur_ext) begin
                        if (cur_ext >= cnt_dec)
                           cur_in = (cnt_dec == '0) ? '0 : IDX_W'(cnt_dec - 1'b1);
                        else if (can_b) cur_in = cur_ff - 1'b1;
                     end
                  end else if (mode_ff == MODE_DROP_BK) begin
                     cur_in = cur_ff - 1'b1;
                  end
               end else begin
                  wr_in = wr_ff + 1'b1;
               end
            end
         end
         ST_APPEND: begin
            cnt_in = cnt_ff + 1'b1;
            cur_in = cnt_ff[IDX_W-1:0];
         end
         ST_LIST_RD: ;
         ST_LIST_WAIT: begin
            page_in  = mem_rdata;
            found_in = 1'b1;
            last_in  = (rd_ff == '0);
         end
         ST_EMIT: begin
            if (rsp_ready && !last_ff) rd_in = rd_ff - 1'b1;
         end
         default: ;
      endcase
   end

   // Outputs and RAM control.
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT);
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = mem_rdata;
      mem_raddr = rd_ff[IDX_W-1:0];
      unique case (state_ff)
         ST_EXEC: begin
            unique case (mode_ff)
               MODE_RECORD: begin
                  // seed an empty history with the source page
                  mem_we    = (dst_ff != '0) && (cnt_ff == '0) && (src_ff != '0);
                  mem_wdata = src_ff;
               end
               MODE_BACK, MODE_PEEK_BK, MODE_LIST: mem_raddr = cur_ff - 1'b1;
               MODE_FORWARD, MODE_PEEK_FW:         mem_raddr = cur_ff + 1'b1;
               default: ;
            endcase
         end
         ST_WALK: begin
            // keep a survivor: pack it down to the write pointer
            mem_we    = pend_ff && !walk_hit;
            mem_waddr = wr_ff[IDX_W-1:0];
         end
         ST_APPEND: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[IDX_W-1:0];
            mem_wdata = dst_ff;
         end
         default: ;
      endcase
   end

   assign rsp_page_out    = 16'(page_ff);
   assign rsp_found       = found_ff;
   assign rsp_can_back    = can_b;
   assign rsp_can_forward = can_f;
   assign rsp_entry_count = 6'(cnt_ff);
   assign rsp_cursor_pos  = 5'(cur_ff);
   assign rsp_last        = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         cur_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         cur_ff   <= cur_in;
         pend_ff  <= pend_in;
      end
      mode_ff     <= mode_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      rd_ff       <= rd_in;
      wr_ff       <= wr_in;
      end_ff      <= end_in;
      pidx_ff     <= pidx_in;
      drop_ff     <= drop_in;
      by_value_ff <= by_value_in;
      page_ff     <= page_in;
      found_ff    <= found_in;
      last_ff     <= last_in;
   end

   // cursor stays inside the history between items
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ((cur_ext < cnt_ff) || (cnt_ff == '0 && cur_ff == '0)))
      else $error("cursor outside history");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (cnt_ff <= CNT_W'(HISTORY_DEPTH)))
      else $error("entry count above depth");

   // compaction never writes ahead of the entry it has read
   a_walk_pack: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && mem_we) |-> (mem_waddr <= pidx_ff))
      else $error("compaction overtook the read pointer");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("accepting while a result is pending");

endmodule
